>>> sv/bbc_pkg.sv
package bbc_pkg;

   // image geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // field and accumulator widths
   localparam int PIXEL_W = 8;
   localparam int SUM_W   = 30;
   localparam int COUNT_W = 21;
   localparam int CENT_W  = 14;
   localparam int FRAC_W  = 4;
   localparam int SHIFT_W = CENT_W - FRAC_W;
   localparam int STEP_W  = $clog2(CENT_W);

   localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = COUNT_W'(1200);
   localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX         = {SUM_W{1'b1}};
   localparam logic [CENT_W-1:0]  CENT_MAX        = {CENT_W{1'b1}};
   localparam logic [COL_W-1:0]   COL_LAST        = COL_W'(MAX_WIDTH - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST        = ROW_W'(MAX_HEIGHT - 1);

   // frame queue between the accumulator and the divider
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               end_of_line;
      logic               end_of_frame;
   } req_type;

   typedef struct packed {
      logic [CENT_W-1:0]  centroid_x;
      logic [CENT_W-1:0]  centroid_y;
      logic               found;
      logic [COUNT_W-1:0] object_pixels;
   } rsp_type;

   // totals of one finished frame
   typedef struct packed {
      logic [SUM_W-1:0]   sum_x;
      logic [SUM_W-1:0]   sum_y;
      logic [COUNT_W-1:0] count;
      logic               found;
   } frame_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_SEND
   } back_state_type;

endpackage

>>> sv/bbc_front.sv
module bbc_front
   import bbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   input  logic               queue_full,
   output logic               push,
   output frame_type          push_data
);

   logic [COUNT_W-1:0] min_count_ff;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [SUM_W-1:0]   sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]   sum_y_ff, sum_y_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               accept;
   logic               hit;
   logic [SUM_W:0]     add_x, add_y;
   logic [SUM_W-1:0]   new_x, new_y;
   logic [COUNT_W-1:0] new_count;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign hit       = (req_data.pixel != '0);

   // saturating accumulation
   assign add_x = {1'b0, sum_x_ff} + (SUM_W + 1)'(column_ff);
   assign add_y = {1'b0, sum_y_ff} + (SUM_W + 1)'(row_ff);

   always_comb begin
      new_x     = sum_x_ff;
      new_y     = sum_y_ff;
      new_count = count_ff;
      if (hit) begin
         new_x = add_x[SUM_W] ? SUM_MAX : add_x[SUM_W-1:0];
         new_y = add_y[SUM_W] ? SUM_MAX : add_y[SUM_W-1:0];
         if (count_ff != COUNT_MAX) begin
            new_count = count_ff + COUNT_W'(1);
         end
      end
   end

   assign push            = accept && req_data.end_of_frame;
   assign push_data.sum_x = new_x;
   assign push_data.sum_y = new_y;
   assign push_data.count = new_count;
   assign push_data.found = (new_count > min_count_ff);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      count_in  = count_ff;
      if (accept) begin
         if (req_data.end_of_frame) begin
            column_in = '0;
            row_in    = '0;
            sum_x_in  = '0;
            sum_y_in  = '0;
            count_in  = '0;
         end else begin
            sum_x_in = new_x;
            sum_y_in = new_y;
            count_in = new_count;
            if (req_data.end_of_line) begin
               column_in = '0;
               if (row_ff != ROW_LAST) begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else if (column_ff != COL_LAST) begin
               column_in = column_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_count_ff <= MIN_COUNT_RESET;
         column_ff    <= '0;
         row_ff       <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            min_count_ff <= csr_wr_data;
         end
         column_ff <= column_in;
         row_ff    <= row_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/bbc_queue.sv
module bbc_queue
   import bbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   output logic      full,
   input  logic      pop,
   output frame_type pop_data,
   output logic      empty
);

   frame_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0]   fill_ff;

   assign full     = (fill_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + QUEUE_AW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + QUEUE_CW'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - QUEUE_CW'(1);
         end
      end
   end

endmodule

>>> sv/bbc_back.sv
module bbc_back
   import bbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      queue_empty,
   input  frame_type pop_data,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   back_state_type     state_ff, state_in;
   frame_type          job_ff, job_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [CENT_W-1:0]  bits_ff, bits_in;
   logic [CENT_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               sel_y_ff, sel_y_in;
   logic               sat_ff, sat_in;
   logic [CENT_W-1:0]  cx_ff, cx_in;
   logic [CENT_W-1:0]  cy_ff, cy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [SUM_W-1:0]   sum_sel;
   logic [COUNT_W:0]   trial;
   logic               ge;
   logic [COUNT_W-1:0] rem_next;
   logic [CENT_W-1:0]  quo_next;
   logic [CENT_W-1:0]  result;
   logic               slot_free;

   assign sum_sel   = sel_y_ff ? job_ff.sum_y : job_ff.sum_x;

   // one quotient bit per cycle
   assign trial     = {rem_ff, bits_ff[CENT_W-1]};
   assign ge        = (trial >= {1'b0, job_ff.count});
   assign rem_next  = ge ? COUNT_W'(trial - {1'b0, job_ff.count}) : trial[COUNT_W-1:0];
   assign quo_next  = {quo_ff[CENT_W-2:0], ge};
   assign result    = sat_ff ? CENT_MAX : quo_next;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      bits_in      = bits_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      sel_y_in     = sel_y_ff;
      sat_in       = sat_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      pop          = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               job_in   = pop_data;
               sel_y_in = 1'b0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // quotient overflows 14 bits when the high part reaches the count
            rem_in   = COUNT_W'(sum_sel[SUM_W-1:SHIFT_W]);
            sat_in   = (COUNT_W'(sum_sel[SUM_W-1:SHIFT_W]) >= job_ff.count);
            bits_in  = {sum_sel[SHIFT_W-1:0], {FRAC_W{1'b0}}};
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            bits_in = bits_ff << 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CENT_W - 1)) begin
               if (sel_y_ff) begin
                  cy_in    = result;
                  state_in = ST_SEND;
               end else begin
                  cx_in    = result;
                  sel_y_in = 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.centroid_x    = job_ff.found ? cx_ff : '0;
               rsp_data_in.centroid_y    = job_ff.found ? cy_ff : '0;
               rsp_data_in.found         = job_ff.found;
               rsp_data_in.object_pixels = job_ff.count;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rem_ff      <= rem_in;
      bits_ff     <= bits_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      sel_y_ff    <= sel_y_in;
      sat_ff      <= sat_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/binary_blob_centroid.sv
// channel | direction | handshake            | word
// req     | in        | req_valid, req_stall | req_type: pixel, end_of_line, end_of_frame
// rsp     | out       | rsp_valid, rsp_stall | rsp_type: centroid_x, centroid_y, found, pixels
// csr     | in        | csr_wr_en            | min_pixel_count, 21 bits
//
// pixels enter at one per clock; req_stall rises only while the frame queue holds two frames
// each frame end runs the divider through a load and a run state per axis, x then y, one quotient bit a cycle
// a result lands in the output register and waits there while the next frame is accumulated
// synchronous active-high reset; threshold resets to 1200, accumulators and queue to empty
// no clearing pass after reset: the first word can be taken in the cycle after reset drops
module binary_blob_centroid
   import bbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   // front to queue
   logic      push;
   frame_type push_data;
   logic      queue_full;

   // queue to back
   logic      pop;
   frame_type pop_data;
   logic      queue_empty;

   // accumulator: column/row tracking, saturating sums, hit count, threshold compare
   bbc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // two-frame queue of totals, lets the pixel side run while the divider works
   bbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // shared restoring divider, x then y, plus output register
   bbc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // a frame total is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !queue_full)
      else $error("frame pushed into full queue");

   // the divider only pulls from a nonempty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> !queue_empty)
      else $error("pop from empty queue");

   // a frame below threshold reports zero centroids
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.centroid_x == '0 && rsp_data.centroid_y == '0))
      else $error("nonzero centroid without found");

endmodule

>>> verif/tb.sv
module tb;
   import bbc_pkg::*;

   // bench timing and run size
   localparam int SETTLE_CYCLES = 40;    // one divider pass plus margin
   localparam int QUIET_LIMIT   = 4000;  // cycles with no transfer before giving up
   localparam int WORD_TARGET   = 650;
   localparam int PHASE_WORDS   = 80;
   localparam int MAX_REPORTS   = 40;

   typedef enum logic {
      PLAN_WORD,
      PLAN_CSR
   } plan_kind_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // one row of the directed table
   typedef struct {
      plan_kind_type      kind;
      req_type            word;
      logic [COUNT_W-1:0] csr_value;
      bit                 typed;
      rsp_type            want;
   } plan_row_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   req_type            req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   rsp_type            rsp_data;

   binary_blob_centroid u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted accumulator state, mirrors the block between frame ends
   logic [COL_W-1:0]   cur_col   = '0;
   logic [ROW_W-1:0]   cur_row   = '0;
   logic [SUM_W-1:0]   col_sum   = '0;
   logic [SUM_W-1:0]   row_sum   = '0;
   logic [COUNT_W-1:0] hit_total = '0;
   logic [COUNT_W-1:0] min_count = MIN_COUNT_RESET;

   rsp_type      frame_results_due[$];  // centroid words still owed by the block
   plan_row_type plan[$];

   int error_count   = 0;
   int words_sent    = 0;
   int frames_seen   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // saturating add for the coordinate sums
   function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   // floor(sum * 16 / n), clamped to the q10.4 range
   function automatic logic [CENT_W-1:0] fixed_mean(input logic [SUM_W-1:0] sum,
                                                     input logic [COUNT_W-1:0] n);
      logic [SUM_W+FRAC_W-1:0] q;
      if (n == '0) return '0;
      q = {sum, {FRAC_W{1'b0}}} / (SUM_W+FRAC_W)'(n);
      return (q > (SUM_W+FRAC_W)'(CENT_MAX)) ? CENT_MAX : q[CENT_W-1:0];
   endfunction

   // advance the predicted state by one pixel word; returns 1 on a frame end
   function automatic bit centroid_step(input req_type w, output rsp_type r);
      r = '0;
      if (w.pixel != '0) begin
         col_sum = sat_sum(col_sum, SUM_W'(cur_col));
         row_sum = sat_sum(row_sum, SUM_W'(cur_row));
         if (hit_total != COUNT_MAX) hit_total = hit_total + 1'b1;
      end
      if (w.end_of_frame) begin
         // the last pixel is already counted; end of line here changes nothing
         r.found         = hit_total > min_count;
         r.object_pixels = hit_total;
         if (r.found) begin
            r.centroid_x = fixed_mean(col_sum, hit_total);
            r.centroid_y = fixed_mean(row_sum, hit_total);
         end
         cur_col   = '0;
         cur_row   = '0;
         col_sum   = '0;
         row_sum   = '0;
         hit_total = '0;
         return 1'b1;
      end
      if (w.end_of_line) begin
         cur_col = '0;
         // rows past the limit pile up on the last row
         if (cur_row != ROW_LAST) cur_row = cur_row + 1'b1;
      end else if (cur_col != COL_LAST) begin
         // overlong rows hold at the last column
         cur_col = cur_col + 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MAX_REPORTS) $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic compare_result(input rsp_type got, input rsp_type want);
      if (got.centroid_x !== want.centroid_x)
         report_error($sformatf("frame %0d centroid_x got %0d want %0d",
                                frames_seen, got.centroid_x, want.centroid_x));
      if (got.centroid_y !== want.centroid_y)
         report_error($sformatf("frame %0d centroid_y got %0d want %0d",
                                frames_seen, got.centroid_y, want.centroid_y));
      if (got.found !== want.found)
         report_error($sformatf("frame %0d found got %0d want %0d",
                                frames_seen, got.found, want.found));
      if (got.object_pixels !== want.object_pixels)
         report_error($sformatf("frame %0d object_pixels got %0d want %0d",
                                frames_seen, got.object_pixels, want.object_pixels));
   endtask

   // result side: random stall per the current idling mode
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // result checker, samples the values that held at the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_results_due.size() == 0)
            report_error($sformatf("result word %0d with no frame pending", frames_seen));
         else
            compare_result(rsp_data, frame_results_due.pop_front());
         frames_seen++;
      end
   end

   // watchdog: ends the run after a long stretch with no transfer at all
   initial begin
      int quiet;
      quiet = 0;
      do begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end while (quiet < QUIET_LIMIT);
      $display("binary_blob_centroid test failed");
      $finish;
   end

   task automatic set_idling(input idle_mode_type mode);
      unique case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 52;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 52;
         end
         default: begin
            send_idle_pct = 33;
            stall_pct     = 33;
         end
      endcase
   endtask

   // present one pixel word, hold it until taken, then predict
   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type pred;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (centroid_step(w, pred)) begin
         // rows with a hand-written answer use it, the rest use the prediction
         frame_results_due.push_back(typed ? want : pred);
      end
   endtask

   // stop sending, let every owed result drain, then let the divider go quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // threshold writes only happen with the block idle
   task automatic program_min_count(input logic [COUNT_W-1:0] v);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      min_count = v;
   endtask

   // one random frame: mostly well-formed rasters, sometimes raw noise
   task automatic send_blob_frame();
      int      width;
      int      height;
      int      density;
      int      n;
      req_type w;
      if ($urandom_range(0, 9) == 0) begin
         // noise: free flags anywhere, closed by a frame end so phases stay clean
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++) begin
            w = req_type'(10'($urandom_range(0, 1023)));
            if (i == n - 1) w.end_of_frame = 1'b1;
            send_word(w, 1'b0, '0);
         end
      end else begin
         width   = $urandom_range(1, 10);
         height  = $urandom_range(1, 6);
         density = $urandom_range(0, 100);
         for (int y = 0; y < height; y++) begin
            for (int x = 0; x < width; x++) begin
               w.pixel        = ($urandom_range(0, 99) < density) ?
                                PIXEL_W'($urandom_range(1, 255)) : '0;
               w.end_of_line  = (x == width - 1);
               w.end_of_frame = (x == width - 1) && (y == height - 1);
               send_word(w, 1'b0, '0);
            end
         end
      end
   endtask

   // directed table builders
   function automatic rsp_type make_rsp(input int cx, input int cy, input bit f, input int n);
      rsp_type r;
      r.centroid_x    = CENT_W'(cx);
      r.centroid_y    = CENT_W'(cy);
      r.found         = f;
      r.object_pixels = COUNT_W'(n);
      return r;
   endfunction

   function automatic void add_word(input int pix, input bit eol, input bit eof);
      plan_row_type row;
      row.kind              = PLAN_WORD;
      row.word.pixel        = PIXEL_W'(pix);
      row.word.end_of_line  = eol;
      row.word.end_of_frame = eof;
      row.csr_value         = '0;
      row.typed             = 1'b0;
      row.want              = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_word_typed(input int pix, input bit eol, input bit eof,
                                          input rsp_type want);
      add_word(pix, eol, eof);
      plan[$].typed = 1'b1;
      plan[$].want  = want;
   endfunction

   function automatic void add_csr(input logic [COUNT_W-1:0] v);
      plan_row_type row;
      row.kind      = PLAN_CSR;
      row.word      = '0;
      row.csr_value = v;
      row.typed     = 1'b0;
      row.want      = '0;
      plan.push_back(row);
   endfunction

   initial begin
      int                 phase;
      int                 phase_end;
      logic [COUNT_W-1:0] thr;

      // reset threshold: a frame with no object, then one object pixel with end of line too
      add_word_typed(8'h00, 1'b0, 1'b1, make_rsp(0, 0, 1'b0, 0));
      add_word_typed(8'hFF, 1'b1, 1'b1, make_rsp(0, 0, 1'b0, 1));
      // threshold zero: lone pixel at the origin is found
      add_csr('0);
      add_word_typed(8'h01, 1'b0, 1'b1, make_rsp(0, 0, 1'b1, 1));
      // two short rows
      add_word(8'h80, 1'b0, 1'b0);
      add_word(8'h00, 1'b0, 1'b0);
      add_word(8'hFF, 1'b1, 1'b0);
      add_word(8'h01, 1'b0, 1'b0);
      add_word(8'h7F, 1'b0, 1'b1);
      // empty row in the middle of a frame
      add_word(8'h55, 1'b0, 1'b0);
      add_word(8'hAA, 1'b1, 1'b0);
      add_word(8'h00, 1'b1, 1'b0);
      add_word(8'h10, 1'b0, 1'b0);
      add_word(8'h00, 1'b0, 1'b0);
      add_word(8'h02, 1'b0, 1'b1);
      // largest threshold: never found
      add_csr(COUNT_MAX);
      add_word(8'hFF, 1'b0, 1'b0);
      add_word_typed(8'hFF, 1'b0, 1'b1, make_rsp(0, 0, 1'b0, 2));
      // count equal to the threshold is not enough, one more is
      add_csr(COUNT_W'(3));
      add_word(8'h04, 1'b0, 1'b0);
      add_word(8'h08, 1'b1, 1'b0);
      add_word_typed(8'h20, 1'b0, 1'b1, make_rsp(0, 0, 1'b0, 3));
      add_word(8'h40, 1'b0, 1'b0);
      add_word(8'h01, 1'b0, 1'b0);
      add_word(8'h01, 1'b1, 1'b0);
      add_word(8'h01, 1'b0, 1'b1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);
      foreach (plan[i]) begin
         if (plan[i].kind == PLAN_CSR)
            program_min_count(plan[i].csr_value);
         else
            send_word(plan[i].word, plan[i].typed, plan[i].want);
      end

      // random phases, each under its own threshold and idling mode
      phase = 0;
      while (words_sent < WORD_TARGET) begin
         unique case (phase % 5)
            0:       thr = '0;
            1:       thr = COUNT_W'($urandom_range(1, 8));
            2:       thr = COUNT_MAX;
            3:       thr = COUNT_W'($urandom_range(9, 40));
            default: thr = MIN_COUNT_RESET;
         endcase
         program_min_count(thr);
         set_idling(idle_mode_type'(phase % 4));
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) send_blob_frame();
         phase++;
      end

      settle_block();
      if (error_count == 0)
         $display("binary_blob_centroid test passed");
      else
         $display("binary_blob_centroid test failed");
      $finish;
   end

endmodule
